@@ design/fpn_pkg.sv @@
// Shared constants, types and functions for the fractal Perlin noise pipeline.
// Holds the quarter-wave gradient table, which is built when the design elaborates.
// Used by fpn_corner, fpn_octave and fractal_perlin_noise_pixel; depends on nothing.
`timescale 1ns / 1ps

package fpn_pkg;

  // Noise structure.
  localparam int OCTAVES    = 12;
  localparam int ANGLE_BITS = 10;
  localparam int QUARTER_N  = 1 << (ANGLE_BITS - 2);
  localparam int QIW        = ANGLE_BITS - 1;
  localparam int OCT_IW     = (OCTAVES > 1) ? $clog2(OCTAVES) : 1;

  // Field and datapath widths.
  localparam int PIX_W    = 16;
  localparam int MAXV_W   = 16;
  localparam int SCALE_W  = 24;
  localparam int CFG_W    = 24;
  localparam int POS_W    = PIX_W + SCALE_W;
  localparam int FRAC_W   = 16;
  localparam int GRAD_W   = 16;
  localparam int DX_W     = FRAC_W + 2;
  localparam int PROD_W   = DX_W + GRAD_W;
  localparam int DOT_W    = 20;
  localparam int DIFF_W   = DOT_W + 1;
  localparam int SMOOTH_W = 17;
  localparam int LERP_W   = DIFF_W + SMOOTH_W + 1;
  localparam int SUM_W    = DOT_W + 4;
  localparam int CON_W    = 18;
  localparam int CPROD_W  = SUM_W + CON_W;
  localparam int CLIP_W   = CPROD_W - 16;
  localparam int OFF_W    = 18;
  localparam int MAP_W    = OFF_W + MAXV_W;

  // Pipeline depths.
  localparam int CORNER_LAT = 3;
  localparam int OCT_LAT    = 10;
  localparam int NGROUP     = (OCTAVES + 3) / 4;

  // Configuration register indexes.
  localparam logic CFG_MAX_VALUE  = 1'b0;
  localparam logic CFG_CELL_SCALE = 1'b1;

  // Gradient quadrant codes.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Arithmetic constants.
  localparam logic [31:0] HASH_K1     = 32'd3284157443;
  localparam logic [31:0] HASH_K2     = 32'd1911520717;
  localparam logic [31:0] HASH_K3     = 32'd2048419325;
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [CON_W-1:0] CONTRAST_Q16 = CON_W'(78643);
  localparam logic [SMOOTH_W:0] SMOOTH_K = (SMOOTH_W + 1)'(196608);
  localparam int CLIP_ONE = 65536;

  typedef logic signed [GRAD_W-1:0] grad_t;
  typedef grad_t quarter_rom_t [QUARTER_N + 1];

  // Quarter-wave sine in Q1.14 by an integer Taylor series in Q2.30.
  function automatic quarter_rom_t build_quarter_rom();
    quarter_rom_t rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] acc;
    logic signed [63:0] v;
    for (int k = 0; k <= QUARTER_N; k++) begin
      x    = (PI_HALF_Q30 * 64'(k)) >> (ANGLE_BITS - 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = $signed(x);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n % 2) == 1) begin
          acc = acc - $signed(term);
        end else begin
          acc = acc + $signed(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      v = (acc + 64'sd32768) >>> 16;
      if (v > 64'sd16384) begin
        v = 64'sd16384;
      end
      rom[k] = GRAD_W'(v);
    end
    return rom;
  endfunction

  localparam quarter_rom_t QUARTER_ROM = build_quarter_rom();

  // Swap the two halves of a 32-bit word.
  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

endpackage

@@ design/fpn_corner.sv @@
// One lattice corner: gradient lookup from the hash and the dot product with the offset.
// Three register stages: table read, two products, sum and scale.
// Depends on fpn_pkg.
`timescale 1ns / 1ps

module fpn_corner (
  input  logic                                 clk,
  input  logic [fpn_pkg::ANGLE_BITS-1:0]       angle,
  input  logic signed [fpn_pkg::DX_W-1:0]      dx,
  input  logic signed [fpn_pkg::DX_W-1:0]      dy,
  output logic signed [fpn_pkg::DOT_W-1:0]     dot
);
  import fpn_pkg::*;

  logic [1:0]        quad;
  logic [QIW-1:0]    ra;
  logic [QIW-1:0]    rb;
  grad_t             ga;
  grad_t             gb;
  grad_t             gs_next;
  grad_t             gc_next;
  grad_t             gs;
  grad_t             gc;
  logic signed [DX_W-1:0]   dx1;
  logic signed [DX_W-1:0]   dy1;
  logic signed [PROD_W-1:0] psx;
  logic signed [PROD_W-1:0] pcy;
  logic signed [PROD_W:0]   dsum;

  // The quadrant picks signs and the swap of the two table reads.
  assign quad = angle[ANGLE_BITS-1 -: 2];
  assign ra   = {1'b0, angle[ANGLE_BITS-3:0]};
  assign rb   = QIW'(QUARTER_N) - ra;
  assign ga   = QUARTER_ROM[ra];
  assign gb   = QUARTER_ROM[rb];

  always_comb begin
    case (quad)
      QUAD_0: begin
        gs_next = ga;
        gc_next = gb;
      end
      QUAD_1: begin
        gs_next = gb;
        gc_next = -ga;
      end
      QUAD_2: begin
        gs_next = -ga;
        gc_next = -gb;
      end
      QUAD_3: begin
        gs_next = -gb;
        gc_next = ga;
      end
      default: begin
        gs_next = ga;
        gc_next = gb;
      end
    endcase
  end

  // Stage one holds the gradient, stage two the products, stage three the dot.
  assign dsum = {psx[PROD_W-1], psx} + {pcy[PROD_W-1], pcy};

  always_ff @(posedge clk) begin
    gs  <= gs_next;
    gc  <= gc_next;
    dx1 <= dx;
    dy1 <= dy;
    psx <= dx1 * gs;
    pcy <= dy1 * gc;
    dot <= dsum[DOT_W+13:14];
  end

endmodule

@@ design/fpn_octave.sv @@
// One noise octave: lattice split, corner hashes, smoothstep weights and bilinear blend.
// Ten register stages from the scaled position to the shifted octave value.
// Depends on fpn_pkg and fpn_corner.
`timescale 1ns / 1ps

module fpn_octave (
  input  logic                              clk,
  input  logic [fpn_pkg::OCT_IW-1:0]        oct_idx,
  input  logic [fpn_pkg::POS_W-1:0]         bx,
  input  logic [fpn_pkg::POS_W-1:0]         by,
  output logic signed [fpn_pkg::DOT_W-1:0]  noise
);
  import fpn_pkg::*;

  logic [63:0]         pos_x;
  logic [63:0]         pos_y;
  logic [31:0]         ix;
  logic [31:0]         iy;
  logic [FRAC_W-1:0]   fx_in;
  logic [FRAC_W-1:0]   fy_in;

  logic [31:0]         ax1 [2];
  logic [31:0]         iy1;
  logic [FRAC_W-1:0]   fx1;
  logic [FRAC_W-1:0]   fy1;
  logic [31:0]         fxx1;
  logic [31:0]         fyy1;

  logic [31:0]         ax2 [2];
  logic [31:0]         hb2 [2][2];
  logic [FRAC_W-1:0]   fx2;
  logic [FRAC_W-1:0]   fy2;
  logic [SMOOTH_W-1:0] sx2;
  logic [SMOOTH_W-1:0] sy2;
  logic [49:0]         smx;
  logic [49:0]         smy;

  logic [31:0]         hh3 [2][2];
  logic [FRAC_W-1:0]   fx3;
  logic [FRAC_W-1:0]   fy3;
  logic [SMOOTH_W-1:0] sx_d [CORNER_LAT+1];
  logic [SMOOTH_W-1:0] sy_d [CORNER_LAT+1];

  logic signed [DOT_W-1:0]  nd [2][2];
  logic signed [DOT_W-1:0]  n00_7;
  logic signed [DOT_W-1:0]  n01_7;
  logic signed [LERP_W-1:0] tp7;
  logic signed [LERP_W-1:0] bp7;
  logic [SMOOTH_W-1:0]      sy7;
  logic signed [DOT_W-1:0]  top8;
  logic signed [DOT_W-1:0]  bot8;
  logic [SMOOTH_W-1:0]      sy8;
  logic signed [DOT_W-1:0]  top9;
  logic signed [LERP_W-1:0] vp9;
  logic signed [LERP_W-1:0] top_ext;
  logic signed [LERP_W-1:0] vmix;
  logic signed [DOT_W-1:0]  vsum;
  logic signed [SMOOTH_W:0] sxs;
  logic signed [SMOOTH_W:0] sys;

  // Octave position is the base position shifted up by the octave number.
  assign pos_x = {{(64-POS_W){1'b0}}, bx} << oct_idx;
  assign pos_y = {{(64-POS_W){1'b0}}, by} << oct_idx;
  assign ix    = pos_x[55:24];
  assign iy    = pos_y[55:24];
  assign fx_in = pos_x[23:8];
  assign fy_in = pos_y[23:8];

  // Stage one: first hash multiply per column and the squared fractions.
  always_ff @(posedge clk) begin
    ax1[0] <= ix * HASH_K1;
    ax1[1] <= (ix + 32'd1) * HASH_K1;
    iy1    <= iy;
    fx1    <= fx_in;
    fy1    <= fy_in;
    fxx1   <= 32'(fx_in) * 32'(fx_in);
    fyy1   <= 32'(fy_in) * 32'(fy_in);
  end

  // Stage two: row mix and second hash multiply; smoothstep weights.
  assign smx = 50'(fxx1) * 50'(SMOOTH_K - {1'b0, fx1, 1'b0});
  assign smy = 50'(fyy1) * 50'(SMOOTH_K - {1'b0, fy1, 1'b0});

  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      ax2[j]    <= ax1[j];
      hb2[j][0] <= (iy1 ^ rot16(ax1[j])) * HASH_K2;
      hb2[j][1] <= ((iy1 + 32'd1) ^ rot16(ax1[j])) * HASH_K2;
    end
    fx2 <= fx1;
    fy2 <= fy1;
    sx2 <= smx[48:32];
    sy2 <= smy[48:32];
  end

  // Stage three: final hash multiply.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 2; j++) begin
      for (int k = 0; k < 2; k++) begin
        hh3[j][k] <= (ax2[j] ^ rot16(hb2[j][k])) * HASH_K3;
      end
    end
    fx3 <= fx2;
    fy3 <= fy2;
  end

  // Weights wait alongside the corner units, entering beside the fractions.
  always_ff @(posedge clk) begin
    sx_d[0] <= sx2;
    sy_d[0] <= sy2;
    for (int d = 1; d <= CORNER_LAT; d++) begin
      sx_d[d] <= sx_d[d-1];
      sy_d[d] <= sy_d[d-1];
    end
  end

  // Stages four to six: the four corners; the far offset is the fraction less one.
  for (genvar j = 0; j < 2; j++) begin : g_col
    for (genvar k = 0; k < 2; k++) begin : g_row
      fpn_corner u_corner (
        .clk   (clk),
        .angle (hh3[j][k][31 -: ANGLE_BITS]),
        .dx    ((j == 0) ? $signed({2'b00, fx3}) : $signed({2'b11, fx3})),
        .dy    ((k == 0) ? $signed({2'b00, fy3}) : $signed({2'b11, fy3})),
        .dot   (nd[j][k])
      );
    end
  end

  // Stage seven: horizontal blend products.
  assign sxs = $signed({1'b0, sx_d[CORNER_LAT]});

  always_ff @(posedge clk) begin
    n00_7 <= nd[0][0];
    n01_7 <= nd[0][1];
    tp7   <= (DIFF_W'(nd[1][0]) - DIFF_W'(nd[0][0])) * sxs;
    bp7   <= (DIFF_W'(nd[1][1]) - DIFF_W'(nd[0][1])) * sxs;
    sy7   <= sy_d[CORNER_LAT];
  end

  // Stage eight: horizontal blend sums.
  always_ff @(posedge clk) begin
    top8 <= n00_7 + DOT_W'(tp7 >>> 16);
    bot8 <= n01_7 + DOT_W'(bp7 >>> 16);
    sy8  <= sy7;
  end

  // Stage nine: vertical blend product.
  assign sys = $signed({1'b0, sy8});

  always_ff @(posedge clk) begin
    top9 <= top8;
    vp9  <= (DIFF_W'(bot8) - DIFF_W'(top8)) * sys;
  end

  // Stage ten: vertical blend sum, then the octave amplitude.
  assign top_ext = LERP_W'(top9);
  assign vmix    = top_ext + (vp9 >>> 16);
  assign vsum    = DOT_W'(vmix);

  always_ff @(posedge clk) begin
    noise <= vsum >>> oct_idx;
  end

endmodule

@@ design/fractal_perlin_noise_pixel.sv @@
// Top level of the fractal Perlin noise generator: one noise sample per pixel request.
// Holds the configuration registers, position scaling, octave sum and output mapping.
// Depends on fpn_pkg and fpn_octave.
`timescale 1ns / 1ps

// A request is taken at a rising edge with start high and busy low. busy is always low,
// so a new pixel can be sent on every clock cycle and the sustained rate is one sample
// per cycle. Every request flows through a fixed pipeline of 18 register stages: input
// register, position multiply, ten stages inside each octave unit (three hash multiplies,
// gradient table read, two dot product stages, four blend stages), two stages of octave
// summing, contrast multiply, clip, output scaling multiply and the output register.
// The result appears on noise_value with done high for exactly one cycle, in request
// order. The receiver cannot stall the block, so nothing is ever held back. The
// latency is set by these register stages and does not depend on the data. The user
// must write configuration through cfg_we, cfg_index and cfg_data only while no request
// is in flight; the block does not enforce this. Register 0 is max_value and register
// 1 is cell_scale. Reset clears all valid bits and restores max_value to 255 and
// cell_scale to 41943; requests in flight at reset are dropped.

module fractal_perlin_noise_pixel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [fpn_pkg::PIX_W-1:0]     pixel_x,
  input  logic [fpn_pkg::PIX_W-1:0]     pixel_y,
  output logic                          done,
  output logic [fpn_pkg::MAXV_W-1:0]    noise_value,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [fpn_pkg::CFG_W-1:0]     cfg_data
);
  import fpn_pkg::*;

  localparam int V_POS  = 1;
  localparam int V_OCT  = V_POS + OCT_LAT;
  localparam int V_GRP  = V_OCT + 1;
  localparam int V_SUM  = V_GRP + 1;
  localparam int V_CON  = V_SUM + 1;
  localparam int V_CLIP = V_CON + 1;
  localparam int V_MAP  = V_CLIP + 1;
  localparam int LAT    = V_MAP + 1;

  logic [MAXV_W-1:0]  max_value;
  logic [SCALE_W-1:0] cell_scale;
  logic [V_MAP:0]     vld;
  logic               accept;

  logic [PIX_W-1:0]   px0;
  logic [PIX_W-1:0]   py0;
  logic [POS_W-1:0]   bx;
  logic [POS_W-1:0]   by;

  logic signed [DOT_W-1:0] oct_val [OCTAVES];
  logic signed [SUM_W-1:0] grp_next [NGROUP];
  logic signed [SUM_W-1:0] grp [NGROUP];
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] sum;
  logic signed [CPROD_W-1:0] cprod;
  logic signed [CLIP_W-1:0]  cval;
  logic signed [CLIP_W-1:0]  cclip;
  logic [OFF_W-1:0]          off;
  logic [MAP_W-1:0]          map_prod;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_value  <= MAXV_W'(255);
      cell_scale <= SCALE_W'(41943);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_VALUE:  max_value  <= cfg_data[MAXV_W-1:0];
        CFG_CELL_SCALE: cell_scale <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel one stage per cycle beside the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[V_MAP-1:0], accept};
      done <= vld[V_MAP];
    end
  end

  // Input register and position scaling to 16.24 cell units.
  always_ff @(posedge clk) begin
    px0 <= pixel_x;
    py0 <= pixel_y;
    bx  <= POS_W'(px0) * POS_W'(cell_scale);
    by  <= POS_W'(py0) * POS_W'(cell_scale);
  end

  // One unit per octave, all running in parallel.
  for (genvar g = 0; g < OCTAVES; g++) begin : g_oct
    fpn_octave u_octave (
      .clk     (clk),
      .oct_idx (OCT_IW'(g)),
      .bx      (bx),
      .by      (by),
      .noise   (oct_val[g])
    );
  end

  // Octave sum, first in groups of four and then across groups.
  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_next[g] = '0;
      for (int e = 0; e < 4; e++) begin
        if (g * 4 + e < OCTAVES) begin
          grp_next[g] = grp_next[g] + SUM_W'(oct_val[g * 4 + e]);
        end
      end
    end
    sum_next = '0;
    for (int g = 0; g < NGROUP; g++) begin
      sum_next = sum_next + grp[g];
    end
  end

  always_ff @(posedge clk) begin
    grp <= grp_next;
    sum <= sum_next;
  end

  // Contrast gain of 1.2 in Q16.
  always_ff @(posedge clk) begin
    cprod <= CPROD_W'(sum) * $signed({{(CPROD_W-CON_W){1'b0}}, CONTRAST_Q16});
  end

  // Clip to plus or minus one and move the range to start at zero.
  assign cval = cprod[CPROD_W-1:16];

  always_comb begin
    if (cval > CLIP_W'(CLIP_ONE)) begin
      cclip = CLIP_W'(CLIP_ONE);
    end else if (cval < -CLIP_W'(CLIP_ONE)) begin
      cclip = -CLIP_W'(CLIP_ONE);
    end else begin
      cclip = cval;
    end
  end

  always_ff @(posedge clk) begin
    off <= OFF_W'(cclip + CLIP_W'(CLIP_ONE));
  end

  // Scale to the output range and truncate.
  always_ff @(posedge clk) begin
    map_prod    <= MAP_W'(off) * MAP_W'(max_value);
    noise_value <= map_prod[MAXV_W+16:17];
  end

  // Every result strobe must match a request taken at the matching earlier edge.
  a_done_from_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LAT + 1))
    else $error("result strobe without a matching request");

  // The clipped and offset level never exceeds two in Q16.
  a_clip_range: assert property (@(posedge clk) disable iff (rst)
    vld[V_CLIP] |-> (off <= OFF_W'(2 * CLIP_ONE)))
    else $error("clipped level out of range");

  // The output product stays below the range of max_value times two.
  a_map_range: assert property (@(posedge clk) disable iff (rst)
    vld[V_MAP] |-> (map_prod[MAP_W-1] == 1'b0))
    else $error("output scaling product overflow");

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the fractal Perlin noise pixel generator.
// Drives directed pixel requests and random bursts, compares every noise sample with an
// in-bench fixed-point model of the noise; depends on fpn_pkg and the RTL top level.
`timescale 1ns / 1ps

module testbench;

  import fpn_pkg::*;

  localparam int TAIL_CYCLES = 40;
  localparam int IDLE_LIMIT  = 5000;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [PIX_W-1:0]     pixel_x;
  logic [PIX_W-1:0]     pixel_y;
  logic                 done;
  logic [MAXV_W-1:0]    noise_value;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  // Model copy of the configuration registers.
  logic [15:0] model_max_value;
  logic [23:0] model_cell_scale;
  longint      sine_table [QUARTER_N + 1];

  logic [15:0] noise_queue [$];
  int          error_count = 0;
  int          stall_cycles = 0;

  fractal_perlin_noise_pixel uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .done(done), .noise_value(noise_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Quarter-wave sine in Q1.14, evaluated as a Taylor series in Q2.30.
  task automatic make_sine_table();
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint          acc;
    for (int k = 0; k <= QUARTER_N; k++) begin
      angle    = (64'd1686629713 * longint'(k)) / longint'(QUARTER_N);
      angle_sq = (angle * angle) >> 30;
      term     = angle;
      acc      = longint'(angle);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * angle_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc -= longint'(term);
        end else begin
          acc += longint'(term);
        end
      end
      if (acc < 0) acc = 0;
      acc = (acc + 32768) >>> 16;
      if (acc > 16384) acc = 16384;
      sine_table[k] = acc;
    end
  endtask

  function automatic logic [31:0] lattice_hash(logic [31:0] cx, logic [31:0] cy);
    logic [31:0] a;
    logic [31:0] b;
    a = cx * 32'd3284157443;
    b = cy ^ {a[15:0], a[31:16]};
    b = b * 32'd1911520717;
    a = a ^ {b[15:0], b[31:16]};
    a = a * 32'd2048419325;
    return a;
  endfunction

  // Gradient at a lattice corner dotted with the offset, Q1.16 result.
  function automatic longint gradient_dot(logic [31:0] cx, logic [31:0] cy,
                                          longint dx, longint dy);
    logic [31:0] angle_idx;
    int          quadrant;
    int          r;
    longint      sa;
    longint      sb;
    longint      gs;
    longint      gc;
    angle_idx = lattice_hash(cx, cy) >> (32 - ANGLE_BITS);
    quadrant  = (angle_idx >> (ANGLE_BITS - 2)) & 3;
    r         = angle_idx & (QUARTER_N - 1);
    sa        = sine_table[r];
    sb        = sine_table[QUARTER_N - r];
    case (quadrant)
      0: begin gs = sa;  gc = sb;  end
      1: begin gs = sb;  gc = -sa; end
      2: begin gs = -sa; gc = -sb; end
      default: begin gs = -sb; gc = sa; end
    endcase
    return (dx * gs + dy * gc) >>> 14;
  endfunction

  function automatic longint blend(longint a, longint b, longint s);
    return a + (((b - a) * s) >>> 16);
  endfunction

  function automatic longint fade(longint f);
    return (f * f * (196608 - 2 * f)) >>> 32;
  endfunction

  // Expected noise sample for one pixel under the current register values.
  function automatic logic [15:0] predict_noise(logic [15:0] px_in, logic [15:0] py_in);
    longint unsigned base_x;
    longint unsigned base_y;
    longint unsigned pos_x;
    longint unsigned pos_y;
    logic [31:0]     ix;
    logic [31:0]     iy;
    longint          fx;
    longint          fy;
    longint          sx;
    longint          sy;
    longint          top;
    longint          bot;
    longint          total;
    longint          level;
    longint unsigned mapped;
    base_x = longint'(px_in) * longint'(model_cell_scale);
    base_y = longint'(py_in) * longint'(model_cell_scale);
    total  = 0;
    for (int i = 0; i < OCTAVES; i++) begin
      pos_x = base_x << i;
      pos_y = base_y << i;
      ix    = pos_x[55:24];
      iy    = pos_y[55:24];
      fx    = longint'(pos_x[23:8]);
      fy    = longint'(pos_y[23:8]);
      sx    = fade(fx);
      sy    = fade(fy);
      top   = blend(gradient_dot(ix, iy, fx, fy),
                    gradient_dot(ix + 1, iy, fx - 65536, fy), sx);
      bot   = blend(gradient_dot(ix, iy + 1, fx, fy - 65536),
                    gradient_dot(ix + 1, iy + 1, fx - 65536, fy - 65536), sx);
      total += blend(top, bot, sy) >>> i;
    end
    level = (total * 78643) >>> 16;
    if (level > 65536) level = 65536;
    if (level < -65536) level = -65536;
    mapped = (longint'(level + 65536) * longint'(model_max_value)) >> 17;
    return mapped[15:0];
  endfunction

  // Present one pixel request and hold it until the block takes it.
  task automatic send_pixel(logic [15:0] px_in, logic [15:0] py_in);
    start   <= 1'b1;
    pixel_x <= px_in;
    pixel_y <= py_in;
    do @(posedge clk); while (busy);
    noise_queue.push_back(predict_noise(px_in, py_in));
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Stop sending and let every outstanding sample come back.
  task automatic drain_pipeline();
    start <= 1'b0;
    @(posedge clk);
    while (noise_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic index, logic [23:0] value);
    drain_pipeline();
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (index == CFG_MAX_VALUE) begin
      model_max_value = value[15:0];
    end else begin
      model_cell_scale = value;
    end
  endtask

  // Field extremes under reset values, then register extremes and a zero scale.
  task automatic test_directed();
    send_pixel(16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'h0000);
    send_pixel(16'd200, 16'd601);
    write_register(CFG_MAX_VALUE, 24'd65535);
    write_register(CFG_CELL_SCALE, 24'hFFFFFF);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h5555, 16'hAAAA);
    send_pixel(16'd1, 16'd0);
    send_pixel(16'h8000, 16'h7FFF);
    write_register(CFG_CELL_SCALE, 24'd1);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'd1234, 16'd4321);
    write_register(CFG_MAX_VALUE, 24'd0);
    send_pixel(16'hAAAA, 16'h5555);
    send_pixel(16'hFFFF, 16'h0001);
    // A zero scale puts every pixel on the lattice origin: the output is mid-range.
    write_register(CFG_MAX_VALUE, 24'd65535);
    write_register(CFG_CELL_SCALE, 24'd0);
    send_pixel(16'hFFFF, 16'hFFFF);
    send_pixel(16'h1234, 16'h8765);
    write_register(CFG_CELL_SCALE, 24'd41943);
    send_pixel(16'd399, 16'd400);
    send_pixel(16'd800, 16'd799);
  endtask

  // Random pixels in bursts with random gaps, including back-to-back stretches.
  task automatic test_random_phase(int count);
    int burst;
    int sent;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < count; b++) begin
        if ($urandom_range(0, 3) == 0) begin
          send_pixel(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)));
        end else begin
          send_pixel(16'($urandom), 16'($urandom));
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 12));
    end
  endtask

  task automatic test_random_settings();
    logic [23:0] scale;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: scale = 24'd41943;
        1: scale = 24'hFFFFFF;
        2: scale = 24'd1;
        default: scale = 24'($urandom_range(1, 24'hFFFFFF) >> $urandom_range(0, 16));
      endcase
      write_register(CFG_MAX_VALUE, 24'($urandom_range(0, 65535)));
      write_register(CFG_CELL_SCALE, scale);
      test_random_phase(300);
    end
  endtask

  // Compare every sample with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (noise_queue.size() == 0) begin
        $display("%0t: unexpected noise_value %0d", $time, noise_value);
        error_count++;
      end else begin
        if (noise_value !== noise_queue[0]) begin
          $display("%0t: noise_value expected %0d actual %0d", $time, noise_queue[0],
                   noise_value);
          error_count++;
        end
        void'(noise_queue.pop_front());
      end
    end
  end

  // End the run when nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst              = 1'b1;
    start            = 1'b0;
    pixel_x          = '0;
    pixel_y          = '0;
    cfg_we           = 1'b0;
    cfg_index        = CFG_MAX_VALUE;
    cfg_data         = '0;
    model_max_value  = 16'd255;
    model_cell_scale = 24'd41943;
    make_sine_table();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_settings();
    drain_pipeline();
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
